[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sliding window statistics block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define SWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Implication checked in the next cycle, disabled while reset is asserted.
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

[sv/sws_pkg.sv]
// ----------------------------------------------------------------------------
// sws_pkg
// Sizes, constants and sequencer states of the sliding window statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

	localparam int WINDOW      = 120;
	localparam int SAMPLE_BITS = 24;

	// ring index
	localparam int PTR_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	// running sum can never overflow: WINDOW * (2^SAMPLE_BITS - 1)
	localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;

	// scan counter sweeps the ring once
	localparam int CNT_BITS = $clog2(WINDOW + 1);

	// mean = (sum * DIV_MUL) >> DIV_SHIFT, exact for every sum below 2^SUM_BITS
	localparam int DIV_SHIFT     = SUM_BITS + PTR_BITS;
	localparam int DIV_MUL_BITS  = SUM_BITS + 1;
	localparam int DIV_PROD_BITS = SUM_BITS + DIV_MUL_BITS;
	localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = DIV_MUL_BITS'(
		((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	localparam longint unsigned SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;
	localparam longint unsigned MIN_RAW    = 64'd999999;
	localparam logic [SAMPLE_BITS-1:0] MIN_CEIL =
		SAMPLE_BITS'((MIN_RAW > SAMPLE_MAX) ? SAMPLE_MAX : MIN_RAW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_SCAN,
		ST_FLUSH,
		ST_DONE
	} sws_state_t;

endpackage

`default_nettype wire

[sv/sliding_window_stats_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_stats_top
// Minimum (of nonzero samples, capped at MIN_CEIL), maximum and mean over the last WINDOW unsigned samples.
// ----------------------------------------------------------------------------
//
//  channel | signals                               | dir | meaning
//  --------+---------------------------------------+-----+---------------------
//  input   | in_valid, in_ready, sample            | in  | one new sample
//  output  | out_valid, out_ready, window_min/max/ | out | stats over the window
//          | window_avg                            |     | after that sample
//
//  Requests are taken one at a time: the block drops the oldest entry from the
//  sum, stores the sample, sweeps the ring through its single read port,
//  finishes the last compare and scales the sum, waits for the output register
//  to be free, loads it and raises out_valid, and goes back to idle before it
//  takes the next request. The mean is the sum times a fixed reciprocal of
//  WINDOW, taken once after the scan.
//  Reset clears the pointer, the running sum and the per-entry valid bits at
//  once; there is no clearing pass. Stalls on the output hold the result in the
//  output register while the next request is already taken and worked on.
//
`default_nettype none

module sliding_window_stats_top import sws_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [SAMPLE_BITS-1:0] window_min,
	output logic      [SAMPLE_BITS-1:0] window_max,
	output logic      [SAMPLE_BITS-1:0] window_avg
);

	sws_state_t state_q, state_d;

	// control registers
	logic [PTR_BITS-1:0] wp_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                scan_rd_s1;
	logic                out_vld_q;
	logic [WINDOW-1:0]   vld_q;

	// payload registers
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic                   rd_vld_q;
	logic [SAMPLE_BITS-1:0] lo_q, hi_q;
	logic [SAMPLE_BITS-1:0] quo_q;
	logic [SAMPLE_BITS-1:0] min_q, max_q, avg_q;

	// ring memory, one write and one registered read per cycle
	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];

	logic                     in_take;
	logic                     ring_we;
	logic                     out_load;
	logic                     scan_last;
	logic                     scan_rd;
	logic [PTR_BITS-1:0]      rd_addr;
	logic [SAMPLE_BITS-1:0]   entry;
	logic [SUM_BITS-1:0]      sum_new;
	logic [DIV_PROD_BITS-1:0] avg_prod;
	logic [SAMPLE_BITS-1:0]   avg_div;

	// an entry that was never written since reset reads as zero
	assign entry   = rd_vld_q ? rd_data_q : '0;
	assign sum_new = sum_q + SUM_BITS'(sample_q);

	assign scan_last = (cnt_q == CNT_BITS'(WINDOW - 1));
	assign scan_rd   = (state_q == ST_SCAN) && (cnt_q < CNT_BITS'(WINDOW));

	// read the oldest entry while idle, sweep the ring while scanning
	assign rd_addr = (state_q == ST_SCAN) ? cnt_q[PTR_BITS-1:0] : wp_q;

	// divide by WINDOW as a multiply by its reciprocal, then drop the fraction
	assign avg_prod = DIV_PROD_BITS'(sum_q) * DIV_PROD_BITS'(DIV_MUL);
	assign avg_div  = avg_prod[DIV_SHIFT +: SAMPLE_BITS];

	// sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ring_we  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				ring_we = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_vld_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			scan_rd_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
			vld_q      <= '0;
		end else begin
			state_q    <= state_d;
			scan_rd_s1 <= scan_rd;
			// take the oldest entry out of the sum
			if (state_q == ST_SUB) begin
				sum_q <= sum_q - SUM_BITS'(entry);
			end
			// add the new sample, mark its slot and advance the pointer with wrap
			if (ring_we) begin
				sum_q        <= sum_new;
				vld_q[wp_q]  <= 1'b1;
				wp_q         <= (wp_q == PTR_BITS'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
				cnt_q        <= '0;
			end else if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wp_q] <= sample_q;
		end
		rd_data_q <= ring_mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	// shared compare unit and mean scaling
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= sample;
		end
		if (ring_we) begin
			lo_q <= MIN_CEIL;
			hi_q <= '0;
		end else if (scan_rd_s1 && (entry != '0)) begin
			// compare the entry read in the previous scan cycle
			if (entry < lo_q) begin
				lo_q <= entry;
			end
			if (entry > hi_q) begin
				hi_q <= entry;
			end
		end
		// the sum is settled since the store; scale it once
		if (state_q == ST_FLUSH) begin
			quo_q <= avg_div;
		end
		if (out_load) begin
			min_q <= lo_q;
			max_q <= hi_q;
			avg_q <= quo_q;
		end
	end

	assign out_valid  = out_vld_q;
	assign window_min = min_q;
	assign window_max = max_q;
	assign window_avg = avg_q;

endmodule

`default_nettype wire

[sv/sws_checker.sv]
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks of the sliding window statistics block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sws_checker import sws_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [SAMPLE_BITS-1:0] window_min,
	input wire logic [SAMPLE_BITS-1:0] window_max,
	input wire logic [SAMPLE_BITS-1:0] window_avg
);

	logic in_take;
	logic out_wait;

	assign in_take  = in_valid && in_ready;
	assign out_wait = out_valid && !out_ready;

	// a taken request makes the block busy, so in_ready drops after the take
	`SWS_ASSERT_NXT(a_busy_after_take, clk, arst_n, in_take, !in_ready)

	// a stalled result holds its value
	`SWS_ASSERT_NXT(a_out_hold, clk, arst_n, out_wait,
		out_valid && $stable(window_min) && $stable(window_max) && $stable(window_avg))

	// minimum is the ceiling or a nonzero entry, never zero
	`SWS_ASSERT_IMP(a_min_nonzero, clk, arst_n, out_valid, window_min != '0)

	// with any nonzero entry, the minimum cannot exceed the maximum
	`SWS_ASSERT_IMP(a_min_le_max, clk, arst_n, out_valid && (window_max != '0),
		window_min <= window_max)

	// an all-empty window has a zero mean
	`SWS_ASSERT_IMP(a_empty_avg, clk, arst_n, out_valid && (window_max == '0),
		window_avg == '0)

endmodule

bind sliding_window_stats_top sws_checker u_sws_checker (.*);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window min / max / mean block.
// A queue of pending samples feeds a clocked request driver. A clocked result
// monitor checks every result against a local window model, field by field.
// The run passes through four handshake phases with different idle and stall
// rates, and drains completely between phases.
// ----------------------------------------------------------------------------

module tb_top;
	import sws_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 1_000_000;
	// settle time after the last result: one full item plus some margin
	localparam int TAIL_CYCLES  = WINDOW + 16;
	localparam int PHASE_COUNT  = 4;
	localparam int RANDOM_PER_PHASE = 325;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] lo;
		logic [SAMPLE_BITS-1:0] hi;
		logic [SAMPLE_BITS-1:0] avg;
	} window_stats_t;

	// shapes of random sample runs
	typedef enum logic [2:0] {
		MODE_FULL,      // any 24-bit value
		MODE_LOW,       // nonzero and below the minimum ceiling
		MODE_CEIL,      // right around the minimum ceiling
		MODE_TINY,      // very small values, zero included
		MODE_EMPTY_RUN, // long run of zeros that can empty the window
		MODE_TOP_RUN,   // long run of all-ones that can drive the mean to its top
		MODE_SPARSE     // mostly zeros with scattered random values
	} stim_mode_t;

	localparam stim_mode_t MODE_POOL [10] = '{
		MODE_FULL, MODE_FULL, MODE_FULL, MODE_LOW, MODE_LOW,
		MODE_CEIL, MODE_TINY, MODE_EMPTY_RUN, MODE_TOP_RUN, MODE_SPARSE
	};

	// idle and stall rates per phase, in percent of cycles
	localparam int SEND_IDLE_PCT [PHASE_COUNT] = '{0, 68, 0, 7};
	localparam int RECV_STALL_PCT [PHASE_COUNT] = '{0, 0, 68, 7};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] sample = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [SAMPLE_BITS-1:0] window_min;
	logic [SAMPLE_BITS-1:0] window_max;
	logic [SAMPLE_BITS-1:0] window_avg;

	// window model state
	logic [SAMPLE_BITS-1:0] hist_ring [WINDOW];
	logic [PTR_BITS-1:0]    hist_wr_idx = '0;
	logic [SUM_BITS-1:0]    hist_sum = '0;

	logic [SAMPLE_BITS-1:0] pending_samples [$];
	window_stats_t          stats_due [$];

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned requests_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatch_count = 0;
	int unsigned ceiling_only_count = 0;
	int unsigned cycle_count = 0;
	logic [SAMPLE_BITS-1:0] peak_avg = '0;

	sliding_window_stats_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_min (window_min),
		.window_max (window_max),
		.window_avg (window_avg)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Advance the window model by one sample and return the stats it should
	// report: evict the oldest slot from the sum, store the new sample, then
	// scan all slots for nonzero min and max.
	function automatic window_stats_t window_stats_after(input logic [SAMPLE_BITS-1:0] s);
		window_stats_t       r;
		logic [SUM_BITS-1:0] q;
		hist_sum = hist_sum - SUM_BITS'(hist_ring[hist_wr_idx]) + SUM_BITS'(s);
		hist_ring[hist_wr_idx] = s;
		hist_wr_idx = (hist_wr_idx == PTR_BITS'(WINDOW - 1)) ? '0 : hist_wr_idx + 1'b1;
		r.lo = MIN_CEIL;
		r.hi = '0;
		foreach (hist_ring[i]) begin
			if (hist_ring[i] != '0) begin
				if (hist_ring[i] < r.lo)
					r.lo = hist_ring[i];
				if (hist_ring[i] > r.hi)
					r.hi = hist_ring[i];
			end
		end
		q = hist_sum / SUM_BITS'(WINDOW);
		r.avg = q[SAMPLE_BITS-1:0];
		return r;
	endfunction

	function automatic void compare_field(input string field,
			input logic [SAMPLE_BITS-1:0] want, input logic [SAMPLE_BITS-1:0] got);
		if (got !== want) begin
			$error("%s mismatch on result %0d: expected %0d, got %0d",
				field, results_seen, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] draw_sample(input stim_mode_t mode);
		logic [SAMPLE_BITS-1:0] v;
		case (mode)
			MODE_LOW:       v = SAMPLE_BITS'($urandom_range(1, int'(MIN_CEIL) - 1));
			MODE_CEIL:      v = MIN_CEIL + SAMPLE_BITS'($urandom_range(0, 4)) - 2'd2;
			MODE_TINY:      v = SAMPLE_BITS'($urandom_range(0, 15));
			MODE_EMPTY_RUN: v = '0;
			MODE_TOP_RUN:   v = '1;
			MODE_SPARSE:    v = ($urandom_range(99, 0) < 75) ? '0 : SAMPLE_BITS'($urandom());
			default:        v = SAMPLE_BITS'($urandom());
		endcase
		return v;
	endfunction

	// Queue n random samples as runs of one shape each. Long runs of zeros and
	// of all-ones are needed to empty the window and to drive the mean to its
	// top, so all-ones runs span WINDOW - 20 to WINDOW + 20 and zero runs WINDOW / 2 to WINDOW + 10.
	task automatic queue_random(input int n);
		stim_mode_t mode;
		int         run;
		int         k;
		k = 0;
		while (k < n) begin
			mode = MODE_POOL[$urandom_range(9, 0)];
			case (mode)
				MODE_TOP_RUN:   run = $urandom_range(WINDOW - 20, WINDOW + 20);
				MODE_EMPTY_RUN: run = $urandom_range(WINDOW / 2, WINDOW + 10);
				default:        run = $urandom_range(5, 40);
			endcase
			repeat (run) begin
				if (k < n) begin
					pending_samples.push_back(draw_sample(mode));
					k++;
				end
			end
		end
	endtask

	// Hold until every queued request is sent and every result has come back.
	task automatic drain;
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || stats_due.size() != 0);
	endtask

	// Request driver: log each accepted request into the model, then either
	// present the next pending sample or drop valid for an idle cycle.
	// Valid is only lowered when nothing is in flight on the channel.
	always @(posedge clk or negedge arst_n) begin : request_driver
		logic slot_free;
		logic send_now;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				stats_due.push_back(window_stats_after(sample));
				requests_sent++;
			end
			slot_free = !in_valid || in_ready;
			send_now  = slot_free && pending_samples.size() != 0
				&& $urandom_range(99, 0) >= send_idle_pct;
			if (send_now) begin
				sample   <= pending_samples.pop_front();
				in_valid <= 1'b1;
			end else if (slot_free) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor: check each accepted result against the oldest expected
	// stats, then pick out_ready for the next cycle.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		window_stats_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (stats_due.size() == 0) begin
					$error("result %0d arrived with no request outstanding", results_seen);
					mismatch_count++;
				end else begin
					want = stats_due.pop_front();
					compare_field("window_min", want.lo, window_min);
					compare_field("window_max", want.hi, window_max);
					compare_field("window_avg", want.avg, window_avg);
					if (want.lo == MIN_CEIL && want.hi != '0)
						ceiling_only_count++;
					if (want.avg > peak_avg)
						peak_avg = want.avg;
				end
			end
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run as failed once it reaches the cycle limit, progress or not.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles: %0d results still due",
				cycle_count, stats_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : sequencer
		int phase;
		foreach (hist_ring[i])
			hist_ring[i] = '0;

		// Hold reset across the first cycles, release on a rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, no idling. Open on an empty window, then probe the
		// minimum ceiling: samples at or above it must leave the minimum at the
		// ceiling, one below it must lower it. Then the field extremes and
		// alternating bit patterns.
		pending_samples.push_back('0);
		pending_samples.push_back(MIN_CEIL);
		pending_samples.push_back(MIN_CEIL + 1'b1);
		pending_samples.push_back('1);
		pending_samples.push_back(MIN_CEIL - 1'b1);
		pending_samples.push_back(24'd1);
		pending_samples.push_back(24'hAAAAAA);
		pending_samples.push_back(24'h555555);
		pending_samples.push_back('0);
		pending_samples.push_back(24'd2);
		pending_samples.push_back(24'h7FFFFF);
		pending_samples.push_back(24'h800000);
		pending_samples.push_back(24'h0F0F0F);
		pending_samples.push_back(24'hF0F0F0);
		pending_samples.push_back(24'd3);
		pending_samples.push_back('0);

		// Each phase starts only after the previous one has fully drained, so
		// the sender pauses until no result is outstanding at every boundary.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			send_idle_pct  = SEND_IDLE_PCT[phase];
			recv_stall_pct = RECV_STALL_PCT[phase];
			queue_random(RANDOM_PER_PHASE);
			drain();
		end

		// Let one more item time pass so a stray late result would be caught.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (stats_due.size() != 0) begin
			$error("%0d expected results never arrived", stats_due.size());
			mismatch_count++;
		end

		$display("sent %0d samples over %0d handshake phases, checked %0d results",
			requests_sent, PHASE_COUNT, results_seen);
		$display("%0d windows had only entries at or above the ceiling; peak mean %0d",
			ceiling_only_count, peak_avg);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[sliding_window_stats_top.f]
+incdir+sv
sv/sws_pkg.sv
sv/sliding_window_stats_top.sv
sv/sws_checker.sv
verif/tb_top.sv
